// ----- rtl/axis_point_rotator_core_macros.svh -----
// Assertion helpers shared by the rotator RTL.
// Both expect i_clk and i_rst_n in scope; checks are off while reset is held.
`ifndef AXIS_POINT_ROTATOR_CORE_MACROS_SVH
`define AXIS_POINT_ROTATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define APR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define APR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/apr_pkg.sv -----
package apr_pkg;

    // Field widths
    localparam int COORD_BITS       = 16;
    localparam int ANGLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 256;

    // Trig format: unsigned Q1.15 table, signed values need one more bit
    localparam int TRIG_FRAC = 15;
    localparam int ROM_W     = TRIG_FRAC + 1;
    localparam int TRIG_W    = ROM_W + 1;

    // Angle decode
    localparam int PHASE_W = ANGLE_BITS - 2;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);

    // Datapath widths
    localparam int PROD_W = COORD_BITS + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Axis select codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // Quadrant of the turn, from the top two angle bits
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef logic [SINE_TABLE_DEPTH:0][ROM_W-1:0] t_rom;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // One quarter-wave entry: Q30 Taylor series of sin to t^11, rounded to Q15
    function automatic logic [ROM_W-1:0] rom_entry(input int unsigned i);
        longint unsigned xq;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned r;
        longint unsigned s;
        longint unsigned e;
        xq = (longint'(i) << 30) / SINE_TABLE_DEPTH;
        t  = (xq * HALF_PI_Q30) >> 30;
        t2 = (t * t) >> 30;
        r  = Q30_ONE;
        r  = Q30_ONE - ((t2 * r) >> 30) / 110;
        r  = Q30_ONE - ((t2 * r) >> 30) / 72;
        r  = Q30_ONE - ((t2 * r) >> 30) / 42;
        r  = Q30_ONE - ((t2 * r) >> 30) / 20;
        r  = Q30_ONE - ((t2 * r) >> 30) / 6;
        s  = (t * r) >> 30;
        e  = (s + (64'd1 << 14)) >> 15;
        if (e > 64'd32768) begin
            e = 64'd32768;
        end
        return e[ROM_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            rom[i] = rom_entry(i);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

endpackage

// ----- rtl/apr_if.sv -----
// Input word: one point, angle and axis select
interface apr_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [1:0]                               cmd;
    logic signed [apr_pkg::COORD_BITS-1:0]    x_in;
    logic signed [apr_pkg::COORD_BITS-1:0]    y_in;
    logic signed [apr_pkg::COORD_BITS-1:0]    z_in;
    logic [apr_pkg::ANGLE_BITS-1:0]           turn_angle;

    modport source (output valid, cmd, x_in, y_in, z_in, turn_angle, input ready);
    modport sink   (input valid, cmd, x_in, y_in, z_in, turn_angle, output ready);
endinterface

// Output word: rotated point
interface apr_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [apr_pkg::COORD_BITS-1:0]    x_out;
    logic signed [apr_pkg::COORD_BITS-1:0]    y_out;
    logic signed [apr_pkg::COORD_BITS-1:0]    z_out;

    modport source (output valid, x_out, y_out, z_out, input ready);
    modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

// ----- rtl/axis_point_rotator_core.sv -----
// Rotates a signed fixed-point 3D point about the x, y or z axis (cmd 0/1/2; cmd 3 passes
// the point through) by turn_angle, where 2^16 is one full turn. Sine and cosine come from
// a 257-entry quarter-wave Q1.15 table indexed by the truncated angle, without
// interpolation. Each rotated coordinate is the sum of two coordinate*trig products,
// rounded half up at bit 15 and saturated to the coordinate range, so the fixed-point
// format of the coordinates does not matter. The coordinate on the chosen axis is
// unchanged. Four register stages (input, table lookup, multiply, round/saturate) take one
// word per clock while the output is not stalled, moving each word through them in order;
// each stage takes a new word whenever it is empty or its word moves on, so bubbles close
// up while the output is stalled.
`include "axis_point_rotator_core_macros.svh"

module axis_point_rotator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    apr_in_if.sink      i_pnt,
    apr_out_if.source   o_rot
);

    localparam int CW = apr_pkg::COORD_BITS;
    localparam int TW = apr_pkg::TRIG_W;
    localparam int PW = apr_pkg::PROD_W;
    localparam int SW = apr_pkg::SUM_W;
    localparam int IW = apr_pkg::IDX_W;
    localparam int FW = apr_pkg::PHASE_W;

    // Pipeline valids and stage advance
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic en_a, en_b, en_c, en_d;

    assign en_d = !r_d_valid || o_rot.ready;
    assign en_c = !r_c_valid || en_d;
    assign en_b = !r_b_valid || en_c;
    assign en_a = !r_a_valid || en_b;

    assign i_pnt.ready = en_a;

    // Stage A: input register
    apr_pkg::t_axis                  r_a_axis;
    logic signed [CW-1:0]            r_a_x, r_a_y, r_a_z;
    logic [apr_pkg::ANGLE_BITS-1:0]  r_a_angle;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_axis  <= apr_pkg::t_axis'(i_pnt.cmd);
            r_a_x     <= i_pnt.x_in;
            r_a_y     <= i_pnt.y_in;
            r_a_z     <= i_pnt.z_in;
            r_a_angle <= i_pnt.turn_angle;
        end
    end

    // Angle decode and table lookup
    apr_pkg::t_quad          quad;
    logic [FW-1:0]           phase;
    logic [FW+IW-1:0]        phase_scaled;
    logic [IW-1:0]           idx_lo, idx_hi;
    logic signed [TW-1:0]    trig_lo, trig_hi;
    logic signed [TW-1:0]    n_sin, n_cos;

    always_comb begin
        quad         = apr_pkg::t_quad'(r_a_angle[apr_pkg::ANGLE_BITS-1 -: 2]);
        phase        = r_a_angle[FW-1:0];
        phase_scaled = (FW+IW)'(phase) * (FW+IW)'(apr_pkg::SINE_TABLE_DEPTH);
        idx_lo       = phase_scaled[FW+IW-1:FW];
        idx_hi       = IW'(apr_pkg::SINE_TABLE_DEPTH) - idx_lo;
        trig_lo      = {1'b0, apr_pkg::SINE_ROM[idx_lo]};
        trig_hi      = {1'b0, apr_pkg::SINE_ROM[idx_hi]};
        unique case (quad)
            apr_pkg::QUAD_0: begin
                n_sin = trig_lo;
                n_cos = trig_hi;
            end
            apr_pkg::QUAD_1: begin
                n_sin = trig_hi;
                n_cos = -trig_lo;
            end
            apr_pkg::QUAD_2: begin
                n_sin = -trig_lo;
                n_cos = -trig_hi;
            end
            apr_pkg::QUAD_3: begin
                n_sin = -trig_hi;
                n_cos = trig_lo;
            end
        endcase
    end

    // Stage B: trig register
    apr_pkg::t_axis          r_b_axis;
    logic signed [CW-1:0]    r_b_x, r_b_y, r_b_z;
    logic signed [TW-1:0]    r_b_sin, r_b_cos;

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_axis <= r_a_axis;
            r_b_x    <= r_a_x;
            r_b_y    <= r_a_y;
            r_b_z    <= r_a_z;
            r_b_sin  <= n_sin;
            r_b_cos  <= n_cos;
        end
    end

    // Operand pick: p' = p*c - q*s, q' = p*s + q*c
    logic signed [CW-1:0] op_p, op_q;

    always_comb begin
        unique case (r_b_axis)
            apr_pkg::AXIS_X: begin
                op_p = r_b_z;
                op_q = r_b_y;
            end
            apr_pkg::AXIS_Y: begin
                op_p = r_b_x;
                op_q = r_b_z;
            end
            apr_pkg::AXIS_Z, apr_pkg::AXIS_NONE: begin
                op_p = r_b_x;
                op_q = r_b_y;
            end
        endcase
    end

    // Stage C: product register
    apr_pkg::t_axis          r_c_axis;
    logic signed [CW-1:0]    r_c_x, r_c_y, r_c_z;
    logic signed [PW-1:0]    r_c_pc, r_c_qs, r_c_ps, r_c_qc;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_axis <= r_b_axis;
            r_c_x    <= r_b_x;
            r_c_y    <= r_b_y;
            r_c_z    <= r_b_z;
            r_c_pc   <= PW'(op_p) * PW'(r_b_cos);
            r_c_qs   <= PW'(op_q) * PW'(r_b_sin);
            r_c_ps   <= PW'(op_p) * PW'(r_b_sin);
            r_c_qc   <= PW'(op_q) * PW'(r_b_cos);
        end
    end

    // Clamp to the coordinate range
    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) begin
            return v[CW-1:0];
        end else if (v[SW-1]) begin
            return apr_pkg::COORD_MIN;
        end else begin
            return apr_pkg::COORD_MAX;
        end
    endfunction

    // Round, scale back, saturate and place by axis
    logic signed [SW-1:0]  sum_p, sum_q;
    logic signed [CW-1:0]  rot_p, rot_q;
    logic signed [CW-1:0]  n_x, n_y, n_z;

    always_comb begin
        sum_p = SW'(r_c_pc) - SW'(r_c_qs) + apr_pkg::ROUND_HALF;
        sum_q = SW'(r_c_ps) + SW'(r_c_qc) + apr_pkg::ROUND_HALF;
        rot_p = sat(sum_p >>> apr_pkg::TRIG_FRAC);
        rot_q = sat(sum_q >>> apr_pkg::TRIG_FRAC);
        unique case (r_c_axis)
            apr_pkg::AXIS_X: begin
                n_x = r_c_x;
                n_y = rot_q;
                n_z = rot_p;
            end
            apr_pkg::AXIS_Y: begin
                n_x = rot_p;
                n_y = r_c_y;
                n_z = rot_q;
            end
            apr_pkg::AXIS_Z: begin
                n_x = rot_p;
                n_y = rot_q;
                n_z = r_c_z;
            end
            apr_pkg::AXIS_NONE: begin
                n_x = r_c_x;
                n_y = r_c_y;
                n_z = r_c_z;
            end
        endcase
    end

    // Stage D: output register
    logic signed [CW-1:0] r_d_x, r_d_y, r_d_z;

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_x <= n_x;
            r_d_y <= n_y;
            r_d_z <= n_z;
        end
    end

    assign o_rot.valid = r_d_valid;
    assign o_rot.x_out = r_d_x;
    assign o_rot.y_out = r_d_y;
    assign o_rot.z_out = r_d_z;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_pnt.valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
            if (en_d) r_d_valid <= r_c_valid;
        end
    end

    // Checks
    `APR_ASSERT_NOW(a_empty_front_ready, !r_a_valid, i_pnt.ready, "empty input stage not ready")
    `APR_ASSERT_NEXT(a_drain_no_word, o_rot.valid && o_rot.ready && !r_c_valid, !o_rot.valid, "word repeated after drain")
    `APR_ASSERT_NEXT(a_x_axis_keeps_x, en_d && r_c_valid && r_c_axis == apr_pkg::AXIS_X, o_rot.x_out == $past(r_c_x), "x changed on x rotation")
    `APR_ASSERT_NEXT(a_z_axis_keeps_z, en_d && r_c_valid && r_c_axis == apr_pkg::AXIS_Z, o_rot.z_out == $past(r_c_z), "z changed on z rotation")

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One point word as offered on the input channel
    typedef struct {
        apr_pkg::t_axis                          axis;
        logic signed [apr_pkg::COORD_BITS-1:0]   x;
        logic signed [apr_pkg::COORD_BITS-1:0]   y;
        logic signed [apr_pkg::COORD_BITS-1:0]   z;
        logic [apr_pkg::ANGLE_BITS-1:0]          angle;
    } t_point_word;

    // One rotated point as returned on the output channel
    typedef struct {
        logic signed [apr_pkg::COORD_BITS-1:0]   x;
        logic signed [apr_pkg::COORD_BITS-1:0]   y;
        logic signed [apr_pkg::COORD_BITS-1:0]   z;
    } t_rotated_point;

    logic i_clk;
    logic i_rst_n;

    apr_in_if  pnt ();
    apr_out_if rot ();

    axis_point_rotator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pnt   (pnt),
        .o_rot   (rot)
    );

    t_point_word    points_to_send[$];
    t_rotated_point rotations_due[$];
    int             quarter_sine[0:apr_pkg::SINE_TABLE_DEPTH];
    int             mismatches = 0;
    int             total_words = 0;

    // Quarter-wave sine in Q15: fixed-point Taylor series, each Q30 step truncated
    function automatic int sine_q15(int unsigned i);
        longint unsigned series_div[5] = '{110, 72, 42, 20, 6};
        longint unsigned ang;
        longint unsigned t;
        longint unsigned t_sq;
        longint unsigned poly;
        longint unsigned prod;
        longint unsigned q15;
        ang  = (64'(i) << 30) / apr_pkg::SINE_TABLE_DEPTH;
        t    = (ang * apr_pkg::HALF_PI_Q30) >> 30;
        t_sq = (t * t) >> 30;
        poly = apr_pkg::Q30_ONE;
        foreach (series_div[k]) begin
            poly = apr_pkg::Q30_ONE - ((t_sq * poly) >> 30) / series_div[k];
        end
        prod = (t * poly) >> 30;
        q15  = (prod + (64'd1 << 14)) >> 15;
        if (q15 > 64'd32768) begin
            q15 = 64'd32768;
        end
        return int'(q15);
    endfunction

    // a*ca + b*cb, rounded half up at the trig binary point, clamped to coord range
    function automatic logic signed [apr_pkg::COORD_BITS-1:0] mix_sat(longint a, longint ca,
                                                                      longint b, longint cb);
        longint acc;
        acc = (a * ca + b * cb + (64'sd1 <<< (apr_pkg::TRIG_FRAC - 1))) >>> apr_pkg::TRIG_FRAC;
        if (acc > longint'(apr_pkg::COORD_MAX)) begin
            acc = longint'(apr_pkg::COORD_MAX);
        end
        if (acc < longint'(apr_pkg::COORD_MIN)) begin
            acc = longint'(apr_pkg::COORD_MIN);
        end
        return acc[apr_pkg::COORD_BITS-1:0];
    endfunction

    // Expected rotated point for one input word
    function automatic t_rotated_point rotate_point(t_point_word w);
        t_rotated_point  r;
        longint unsigned phase;
        int unsigned     idx;
        longint          near_v;
        longint          far_v;
        longint          sn;
        longint          cs;
        longint          px;
        longint          py;
        longint          pz;
        phase  = 64'(w.angle[apr_pkg::PHASE_W-1:0]);
        idx    = int'((phase * apr_pkg::SINE_TABLE_DEPTH) >> apr_pkg::PHASE_W);
        near_v = quarter_sine[idx];
        far_v  = quarter_sine[apr_pkg::SINE_TABLE_DEPTH - idx];
        case (apr_pkg::t_quad'(w.angle[apr_pkg::ANGLE_BITS-1 -: 2]))
            apr_pkg::QUAD_0: begin sn =  near_v; cs =  far_v;  end
            apr_pkg::QUAD_1: begin sn =  far_v;  cs = -near_v; end
            apr_pkg::QUAD_2: begin sn = -near_v; cs = -far_v;  end
            default: begin sn = -far_v; cs =  near_v; end
        endcase
        px = w.x;
        py = w.y;
        pz = w.z;
        r.x = w.x;
        r.y = w.y;
        r.z = w.z;
        case (w.axis)
            apr_pkg::AXIS_X: begin
                r.y = mix_sat(py, cs, pz, sn);
                r.z = mix_sat(pz, cs, py, -sn);
            end
            apr_pkg::AXIS_Y: begin
                r.x = mix_sat(px, cs, pz, -sn);
                r.z = mix_sat(px, sn, pz, cs);
            end
            apr_pkg::AXIS_Z: begin
                r.x = mix_sat(px, cs, py, -sn);
                r.y = mix_sat(px, sn, py, cs);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_point(apr_pkg::t_axis axis, int x, int y, int z, int angle);
        t_point_word w;
        w.axis  = axis;
        w.x     = x[apr_pkg::COORD_BITS-1:0];
        w.y     = y[apr_pkg::COORD_BITS-1:0];
        w.z     = z[apr_pkg::COORD_BITS-1:0];
        w.angle = angle[apr_pkg::ANGLE_BITS-1:0];
        points_to_send.push_back(w);
    endtask

    function automatic int pick_coord();
        int edge_vals[5] = '{-32768, 32767, 0, -1, 1};
        if ($urandom_range(0, 4) == 0) begin
            return edge_vals[$urandom_range(0, 4)];
        end
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_angle();
        int unsigned q;
        if ($urandom_range(0, 3) == 0) begin
            q = $urandom_range(0, 3) << apr_pkg::PHASE_W;
            return int'((q + $urandom_range(0, 130) - 65) & 16'hffff);
        end
        return int'($urandom_range(0, 65535));
    endfunction

    function automatic apr_pkg::t_axis pick_axis();
        if ($urandom_range(0, 9) == 0) begin
            return apr_pkg::AXIS_NONE;
        end
        return apr_pkg::t_axis'($urandom_range(0, 2));
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Known levels on every input from time zero
    initial begin
        pnt.valid      = 1'b0;
        pnt.cmd        = '0;
        pnt.x_in       = '0;
        pnt.y_in       = '0;
        pnt.z_in       = '0;
        pnt.turn_angle = '0;
        rot.ready      = 1'b0;
    end

    // Input driver: one queued word at a time, random gap after each
    t_point_word on_bus;
    int          send_gap = 0;
    int          sent_words = 0;
    bit          send_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pnt.valid <= 1'b0;
            send_gap  = 0;
        end else begin
            if (pnt.valid && pnt.ready) begin
                rotations_due.push_back(rotate_point(on_bus));
            end
            if (!pnt.valid || pnt.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pnt.valid <= 1'b0;
                end else if (points_to_send.size() > 0) begin
                    on_bus = points_to_send.pop_front();
                    pnt.cmd        <= on_bus.axis;
                    pnt.x_in       <= on_bus.x;
                    pnt.y_in       <= on_bus.y;
                    pnt.z_in       <= on_bus.z;
                    pnt.turn_angle <= on_bus.angle;
                    pnt.valid      <= 1'b1;
                    // switch between back-to-back and gappy stretches
                    if (sent_words % 48 == 0) begin
                        send_calm = $urandom_range(0, 1);
                    end
                    sent_words++;
                    send_gap = send_calm ? 0 : $urandom_range(0, 12);
                end else begin
                    pnt.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: check each word against the oldest prediction, stall at random
    int             hold_left = 0;
    int             seen_words = 0;
    bit             recv_calm = 1'b0;
    t_rotated_point want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rot.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rot.valid && rot.ready) begin
                if (rotations_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                             rot.x_out, rot.y_out, rot.z_out);
                end else begin
                    want = rotations_due.pop_front();
                    if (rot.x_out !== want.x) begin
                        mismatches++;
                        $display("%0t: x_out expected %0d got %0d", $time, want.x, rot.x_out);
                    end
                    if (rot.y_out !== want.y) begin
                        mismatches++;
                        $display("%0t: y_out expected %0d got %0d", $time, want.y, rot.y_out);
                    end
                    if (rot.z_out !== want.z) begin
                        mismatches++;
                        $display("%0t: z_out expected %0d got %0d", $time, want.z, rot.z_out);
                    end
                end
                if (seen_words % 40 == 0) begin
                    recv_calm = $urandom_range(0, 1);
                end
                seen_words++;
                hold_left = recv_calm ? 0 : $urandom_range(0, 12);
            end
            if (hold_left > 0) begin
                hold_left--;
                rot.ready <= 1'b0;
            end else begin
                rot.ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        i_rst_n = 1'b0;
        for (int i = 0; i <= apr_pkg::SINE_TABLE_DEPTH; i++) begin
            quarter_sine[i] = sine_q15(i);
        end

        // every axis at zero angle plus the pass-through code
        queue_point(apr_pkg::AXIS_X, 1000, -2000, 3000, 0);
        queue_point(apr_pkg::AXIS_Y, 1000, -2000, 3000, 0);
        queue_point(apr_pkg::AXIS_Z, 1000, -2000, 3000, 0);
        queue_point(apr_pkg::AXIS_NONE, 32767, -32768, 123, 16'h2000);
        // quadrant boundaries and the top of each quadrant
        queue_point(apr_pkg::AXIS_Z, 256, 512, -768, 16'h4000);
        queue_point(apr_pkg::AXIS_Z, 256, 512, -768, 16'h8000);
        queue_point(apr_pkg::AXIS_Z, 256, 512, -768, 16'hc000);
        queue_point(apr_pkg::AXIS_X, 256, 512, -768, 16'h3fff);
        queue_point(apr_pkg::AXIS_Y, 256, 512, -768, 16'hffff);
        queue_point(apr_pkg::AXIS_X, -300, 7000, -9000, 16'h7fff);
        queue_point(apr_pkg::AXIS_Y, -300, 7000, -9000, 16'hbfff);
        // saturation high and low at 45 degrees
        queue_point(apr_pkg::AXIS_Z, 32767, 32767, 0, 16'h2000);
        queue_point(apr_pkg::AXIS_Z, -32768, -32768, 0, 16'h2000);
        queue_point(apr_pkg::AXIS_X, 0, 32767, 32767, 16'h2000);
        queue_point(apr_pkg::AXIS_Y, 32767, 0, 32767, 16'h2000);
        queue_point(apr_pkg::AXIS_X, 5, -32768, -32768, 16'h2000);
        // negating the most negative coordinate clamps at the top
        queue_point(apr_pkg::AXIS_Z, -32768, -32768, -32768, 16'h8000);
        queue_point(apr_pkg::AXIS_Y, -32768, 32767, -32768, 16'h8000);
        queue_point(apr_pkg::AXIS_X, 32767, -32768, 32767, 16'h4000);
        // small values where rounding decides
        queue_point(apr_pkg::AXIS_Z, 1, -1, 1, 16'h1234);
        queue_point(apr_pkg::AXIS_Y, -1, 1, -1, 16'hedcb);
        queue_point(apr_pkg::AXIS_X, 0, 0, 0, 16'h5555);

        for (int n = 0; n < 800; n++) begin
            queue_point(pick_axis(), pick_coord(), pick_coord(), pick_coord(), pick_angle());
        end
        total_words = points_to_send.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every sent word has come back; then watch for stray extra words
        wait (seen_words >= total_words);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/apr_pkg.sv
rtl/apr_if.sv
rtl/axis_point_rotator_core.sv
tb/sv/tb.sv
